// ----- sv/cpx_pkg.sv -----
// Shared types, constants and the gain table generator for the constant-power crossfade.
package cpx_pkg;

  localparam int FRAME_BITS      = 24;
  localparam int CNT_BITS        = FRAME_BITS + 1;
  localparam int SAMPLE_BITS     = 16;
  localparam int GAIN_BITS       = 16;
  localparam int CHAN_BITS       = 2;
  localparam int NUM_LANES       = 2;
  localparam int GAIN_TABLE_SIZE = 1024;
  localparam int POS_BITS        = $clog2(GAIN_TABLE_SIZE + 1);

  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 5;
  localparam int REG_IDX_BITS = ADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_A_LENGTH       = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_B_LENGTH       = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_FADE_LENGTH    = REG_IDX_BITS'(2);
  localparam logic [REG_IDX_BITS-1:0] REG_A_CHAN_COUNT   = REG_IDX_BITS'(3);
  localparam logic [REG_IDX_BITS-1:0] REG_B_CHAN_COUNT   = REG_IDX_BITS'(4);
  localparam logic [REG_IDX_BITS-1:0] REG_OUT_CHAN_COUNT = REG_IDX_BITS'(5);

  // Hold-off length that lets the derived registers follow a register write.
  localparam int SETTLE_CYCLES = 4;
  localparam int SETTLE_BITS   = $clog2(SETTLE_CYCLES + 1);

  localparam int DIV_SHIFT    = $clog2(2 * GAIN_TABLE_SIZE);
  localparam int DIV_STEPS    = 3;
  localparam int DIV_CYCLES   = (POS_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int QUO_BITS     = DIV_STEPS * DIV_CYCLES;
  localparam int NUM_BITS     = FRAME_BITS + DIV_SHIFT + 1;
  localparam int DEN_SH_BITS  = FRAME_BITS + 1 + QUO_BITS - 1;
  localparam int DIV_BITS     = (NUM_BITS > DEN_SH_BITS) ? NUM_BITS : DEN_SH_BITS;

  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30     = 64'd1073741824;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;
  typedef logic [POS_BITS-1:0]           pos_t;
  typedef logic [FRAME_BITS-1:0]         frame_t;
  typedef logic [CNT_BITS-1:0]           count_t;

  typedef logic [GAIN_BITS-1:0] gain_rom_t [0:GAIN_TABLE_SIZE];

  typedef struct packed {
    frame_t a_len;
    frame_t cfc;
    frame_t start;
    count_t start_b;
    count_t total_m1;
    logic   b_zero;
    logic   a_stereo;
    logic   b_stereo;
    logic   o_stereo;
    logic   busy;
  } cfg_t;

  // Quarter-cosine table in Q1.15, built from a Q30 power series.
  function automatic gain_rom_t gain_rom_init();
    gain_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k <= GAIN_TABLE_SIZE; k++) begin
      x    = (64'(k) * 64'(HALF_PI_Q30)) / GAIN_TABLE_SIZE;
      x2   = (x * x) >> 30;
      term = 64'(ONE_Q30);
      sum  = ONE_Q30;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 16384) >>> 15;
      rom[k] = (sum > 32768) ? GAIN_BITS'(32768) : sum[GAIN_BITS-1:0];
    end
    return rom;
  endfunction

endpackage

// ----- sv/cpx_regs.sv -----
// Register file with its bus port and the fade geometry derived from the registers.
module cpx_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cpx_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [cpx_pkg::DATA_BITS-1:0]    pwdata,
  output logic [cpx_pkg::DATA_BITS-1:0]    prdata,
  output logic                             pready,
  output cpx_pkg::cfg_t                    cfg
);
  import cpx_pkg::*;

  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr_en;
  frame_t                  a_len;
  frame_t                  b_len;
  frame_t                  fade_len;
  logic [CHAN_BITS-1:0]    a_chan;
  logic [CHAN_BITS-1:0]    b_chan;
  logic [CHAN_BITS-1:0]    o_chan;
  logic [SETTLE_BITS-1:0]  settle;

  frame_t cfc;
  count_t ab_sum;
  frame_t start;
  count_t tot;
  count_t start_b;
  count_t tmax;
  count_t total_m1;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_len    <= FRAME_BITS'(1);
      b_len    <= FRAME_BITS'(1);
      fade_len <= '0;
      a_chan   <= CHAN_BITS'(2);
      b_chan   <= CHAN_BITS'(2);
      o_chan   <= CHAN_BITS'(2);
      settle   <= SETTLE_BITS'(SETTLE_CYCLES);
    end else begin
      if (wr_en) begin
        unique case (idx)
          REG_A_LENGTH:       a_len    <= pwdata[FRAME_BITS-1:0];
          REG_B_LENGTH:       b_len    <= pwdata[FRAME_BITS-1:0];
          REG_FADE_LENGTH:    fade_len <= pwdata[FRAME_BITS-1:0];
          REG_A_CHAN_COUNT:   a_chan   <= pwdata[CHAN_BITS-1:0];
          REG_B_CHAN_COUNT:   b_chan   <= pwdata[CHAN_BITS-1:0];
          REG_OUT_CHAN_COUNT: o_chan   <= pwdata[CHAN_BITS-1:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        settle <= SETTLE_BITS'(SETTLE_CYCLES);
      end else if (settle != '0) begin
        settle <= settle - SETTLE_BITS'(1);
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_A_LENGTH:       prdata = DATA_BITS'(a_len);
      REG_B_LENGTH:       prdata = DATA_BITS'(b_len);
      REG_FADE_LENGTH:    prdata = DATA_BITS'(fade_len);
      REG_A_CHAN_COUNT:   prdata = DATA_BITS'(a_chan);
      REG_B_CHAN_COUNT:   prdata = DATA_BITS'(b_chan);
      REG_OUT_CHAN_COUNT: prdata = DATA_BITS'(o_chan);
      default:            prdata = '0;
    endcase
  end

  // The fade is clamped to clip A; the output runs max(a + b - fade, a) frames, at least one.
  always_ff @(posedge clk) begin
    cfc      <= (fade_len > a_len) ? a_len : fade_len;
    ab_sum   <= CNT_BITS'(a_len) + CNT_BITS'(b_len);
    start    <= a_len - cfc;
    tot      <= ab_sum - CNT_BITS'(cfc);
    start_b  <= CNT_BITS'(start) + CNT_BITS'(b_len);
    tmax     <= (tot < CNT_BITS'(a_len)) ? CNT_BITS'(a_len) : tot;
    total_m1 <= (tmax == '0) ? '0 : tmax - CNT_BITS'(1);
  end

  always_comb begin
    cfg.a_len    = a_len;
    cfg.cfc      = cfc;
    cfg.start    = start;
    cfg.start_b  = start_b;
    cfg.total_m1 = total_m1;
    cfg.b_zero   = (b_len == '0);
    cfg.a_stereo = a_chan[1];
    cfg.b_stereo = b_chan[1];
    cfg.o_stereo = o_chan[1];
    cfg.busy     = (settle != '0);
  end

endmodule

// ----- sv/cpx_div.sv -----
// Multi-cycle restoring divider that turns the fade offset into a rounded table position.
module cpx_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  cpx_pkg::frame_t       offset,
  input  cpx_pkg::frame_t       fade,
  output logic                  done,
  output cpx_pkg::pos_t         quo
);
  import cpx_pkg::*;

  logic [DIV_BITS-1:0]     rem;
  logic [DIV_BITS-1:0]     den;
  logic [QUO_BITS-1:0]     q;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;

  logic [DIV_BITS-1:0]     rem_next;
  logic [DIV_BITS-1:0]     den_next;
  logic [QUO_BITS-1:0]     q_next;
  logic                    ge;

  always_comb begin
    rem_next = rem;
    den_next = den;
    q_next   = q;
    ge       = 1'b0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      ge = (rem_next >= den_next);
      if (ge) begin
        rem_next = rem_next - den_next;
      end
      q_next   = {q_next[QUO_BITS-2:0], ge};
      den_next = den_next >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend is offset * 2 * table size + fade, divisor is 2 * fade.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= (DIV_BITS'(offset) << DIV_SHIFT) + DIV_BITS'(fade);
      den <= DIV_BITS'(fade) << QUO_BITS;
      q   <= '0;
    end else if (busy) begin
      rem <= rem_next;
      den <= den_next;
      q   <= q_next;
    end
  end

  assign quo = q[POS_BITS-1:0];

endmodule

// ----- sv/cpx_gain_rom.sv -----
// Quarter-cosine gain table with registered reads for the fade-out and fade-in gains.
module cpx_gain_rom (
  input  logic                 clk,
  input  logic                 rd,
  input  cpx_pkg::pos_t        pos,
  output cpx_pkg::gain_t       gain_a,
  output cpx_pkg::gain_t       gain_b
);
  import cpx_pkg::*;

  localparam gain_rom_t GAIN_ROM = gain_rom_init();

  always_ff @(posedge clk) begin
    if (rd) begin
      gain_a <= GAIN_ROM[pos];
      gain_b <= GAIN_ROM[POS_BITS'(GAIN_TABLE_SIZE) - pos];
    end
  end

endmodule

// ----- sv/cpx_lane.sv -----
// One channel lane: weights both clip samples, then rounds and saturates their sum.
module cpx_lane (
  input  logic                 clk,
  input  logic                 load,
  input  cpx_pkg::gain_t       gain_a,
  input  cpx_pkg::gain_t       gain_b,
  input  cpx_pkg::sample_t     samp_a,
  input  cpx_pkg::sample_t     samp_b,
  output cpx_pkg::sample_t     mix
);
  import cpx_pkg::*;

  localparam int PROD_BITS = GAIN_BITS + SAMPLE_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;

  logic signed [PROD_BITS-1:0] prod_a;
  logic signed [PROD_BITS-1:0] prod_b;
  logic signed [SUM_BITS-1:0]  acc;
  logic signed [SUM_BITS-1:0]  scaled;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_a <= PROD_BITS'($signed({1'b0, gain_a}) * samp_a);
      prod_b <= PROD_BITS'($signed({1'b0, gain_b}) * samp_b);
    end
  end

  always_comb begin
    acc    = SUM_BITS'(prod_a) + SUM_BITS'(prod_b)
           + $signed(SUM_BITS'(1) << (SAMPLE_BITS - 2));
    scaled = acc >>> (SAMPLE_BITS - 1);
    if (scaled > $signed(SUM_BITS'(32767))) begin
      mix = sample_t'(16'sh7fff);
    end else if (scaled < -$signed(SUM_BITS'(32768))) begin
      mix = sample_t'(16'sh8000);
    end else begin
      mix = scaled[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ----- sv/constant_power_crossfade.sv -----
// Top level of the constant-power crossfade: frame sequencing, lanes and output register.
// Outside the fade an item runs from the input transfer through the ROM, MUL and OUT states.
// Inside the fade the position divider runs first, in the DIV state.
// A new item waits until the previous one has been loaded into the output register.
// Synchronous reset clears the frame counter and restores the register defaults;
// input is held off while the registers settle after reset and after each write.
module constant_power_crossfade (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cpx_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [cpx_pkg::DATA_BITS-1:0]    pwdata,
  output logic [cpx_pkg::DATA_BITS-1:0]    prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cpx_pkg::sample_t                 a_left,
  input  cpx_pkg::sample_t                 a_right,
  input  cpx_pkg::sample_t                 b_left,
  input  cpx_pkg::sample_t                 b_right,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cpx_pkg::sample_t                 out_left,
  output cpx_pkg::sample_t                 out_right,
  output logic                             last_frame
);
  import cpx_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_ROM  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t  state;
  cfg_t    cfg;
  count_t  frame_index;

  logic    in_accept;
  logic    a_end;
  logic    past_start;
  logic    b_end;
  logic    is_last;
  logic    need_div;
  count_t  offset;

  logic    div_go;
  logic    div_done;
  pos_t    div_quo;
  frame_t  offset_q;
  pos_t    pos_q;
  logic    last_q;
  logic    out_load;

  gain_t   gain_a;
  gain_t   gain_b;
  sample_t lane_a [NUM_LANES];
  sample_t lane_b [NUM_LANES];
  sample_t lane_mix [NUM_LANES];

  cpx_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  assign in_stall  = (state != S_IDLE) || cfg.busy;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    a_end      = (frame_index >= CNT_BITS'(cfg.a_len));
    past_start = (frame_index >= CNT_BITS'(cfg.start));
    b_end      = past_start ? (frame_index >= cfg.start_b) : cfg.b_zero;
    is_last    = (frame_index >= cfg.total_m1);
    need_div   = (cfg.cfc != '0) && past_start && !a_end;
    offset     = frame_index - CNT_BITS'(cfg.start);
  end

  cpx_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .offset(offset_q),
    .fade  (cfg.cfc),
    .done  (div_done),
    .quo   (div_quo)
  );

  cpx_gain_rom u_rom (
    .clk   (clk),
    .rd    (state == S_ROM),
    .pos   (pos_q),
    .gain_a(gain_a),
    .gain_b(gain_b)
  );

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    cpx_lane u_lane (
      .clk   (clk),
      .load  (state == S_MUL),
      .gain_a(gain_a),
      .gain_b(gain_b),
      .samp_a(lane_a[c]),
      .samp_b(lane_b[c]),
      .mix   (lane_mix[c])
    );
  end

  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_index <= '0;
      out_valid   <= 1'b0;
      div_go      <= 1'b0;
    end else begin
      div_go <= in_accept && need_div;
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            frame_index <= is_last ? '0 : frame_index + CNT_BITS'(1);
            state       <= need_div ? S_DIV : S_ROM;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_ROM;
          end
        end
        S_ROM: state <= S_MUL;
        S_MUL: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Samples past a clip's end are zeroed; a mono source feeds both lanes.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      lane_a[0] <= a_end ? '0 : a_left;
      lane_a[1] <= a_end ? '0 : (cfg.a_stereo ? a_right : a_left);
      lane_b[0] <= b_end ? '0 : b_left;
      lane_b[1] <= b_end ? '0 : (cfg.b_stereo ? b_right : b_left);
      last_q    <= is_last;
      offset_q  <= offset[FRAME_BITS-1:0];
      pos_q     <= a_end ? POS_BITS'(GAIN_TABLE_SIZE) : '0;
    end else if ((state == S_DIV) && div_done) begin
      pos_q <= div_quo;
    end
    if (out_load) begin
      out_left   <= lane_mix[0];
      out_right  <= cfg.o_stereo ? lane_mix[1] : '0;
      last_frame <= last_q;
    end
  end

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_last) |=> (frame_index == '0))
    else $error("frame counter did not return to zero after the last frame");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROM) |-> (pos_q <= POS_BITS'(GAIN_TABLE_SIZE)))
    else $error("gain table position out of range");

endmodule
